[hdl/skc_pkg.sv]
`timescale 1ns / 1ps

package skc_pkg;

    // Default longest seed in bases; the count table has 4**MAX_SEED_LEN entries
    localparam int MAX_SEED_LEN_DEF = 11;

    // Fixed field widths
    localparam int POS_W   = 32;
    localparam int SEQ_W   = 16;
    localparam int VALUE_W = 22;
    localparam int INDEX_W = 22;
    localparam int COUNT_W = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 104;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_OVERLAP = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  SEED_LENGTH_RST  = 4'd11;
    localparam logic [CFG_DATA_W-1:0]  SEED_OVERLAP_RST = 4'd0;

    // Input word kinds
    localparam logic ACT_BASE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Side data of one table access, carried from the sampler to the counter
    typedef struct packed {
        logic             is_read;
        logic [POS_W-1:0] start;
        logic [SEQ_W-1:0] seq;
    } skc_req_t;

endpackage

[hdl/skc_ram.sv]
`timescale 1ns / 1ps

module skc_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 22
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:(64'd1 << ADDR_W) - 64'd1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/skc_sampler.sv]
`timescale 1ns / 1ps

module skc_sampler
    import skc_pkg::*;
#(
    parameter int MAX_SEED_LEN = MAX_SEED_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      accept,
    input  logic                      action,
    input  logic [1:0]                base_code,
    input  logic                      first_in_region,
    input  logic                      last_in_region,
    input  logic [POS_W-1:0]          base_position,
    input  logic [SEQ_W-1:0]          sequence_id,
    input  logic [INDEX_W-1:0]        read_index,
    output logic                      req_valid,
    output skc_req_t                  req,
    output logic [2*MAX_SEED_LEN-1:0] req_addr
);

    localparam int TB    = 2 * MAX_SEED_LEN;
    localparam int LEN_W = $clog2(MAX_SEED_LEN + 1);

    logic [CFG_DATA_W-1:0] seed_length_reg;
    logic [CFG_DATA_W-1:0] seed_overlap_reg;
    logic [TB-1:0]         rolling_reg;
    logic [TB-1:0]         rolling_next;
    logic [LEN_W-1:0]      bases_reg;
    logic [LEN_W-1:0]      bases_next;
    logic [LEN_W-1:0]      phase_reg;
    logic [LEN_W-1:0]      phase_next;

    logic [4:0]    len5;
    logic [4:0]    step5;
    logic [4:0]    b0;
    logic [4:0]    p0;
    logic [4:0]    b1;
    logic [4:0]    p1;
    logic          reached;
    logic          emit;
    logic [5:0]    mask_shift;
    logic [TB-1:0] seed_mask;
    logic [31:0]   read_index_ext;

    // Effective length and step from the registers
    always_comb
    begin
        if (seed_length_reg == '0)
        begin
            len5 = 5'd1;
        end
        else if ({1'b0, seed_length_reg} > 5'(MAX_SEED_LEN))
        begin
            len5 = 5'(MAX_SEED_LEN);
        end
        else
        begin
            len5 = {1'b0, seed_length_reg};
        end

        if ({1'b0, seed_overlap_reg} >= len5)
        begin
            step5 = 5'd1;
        end
        else
        begin
            step5 = len5 - {1'b0, seed_overlap_reg};
        end
    end

    // Advance the region counters for one base
    always_comb
    begin
        rolling_next = TB'({rolling_reg, base_code});
        b0 = first_in_region ? 5'd0 : 5'(bases_reg);
        p0 = first_in_region ? 5'd0 : 5'(phase_reg);
        if (b0 < len5)
        begin
            b1      = b0 + 5'd1;
            reached = (b1 == len5);
            p1      = reached ? 5'd0 : p0;
        end
        else
        begin
            b1      = b0;
            reached = 1'b1;
            p1      = ((p0 + 5'd1) >= step5) ? 5'd0 : (p0 + 5'd1);
        end
        emit = reached && ((p1 == 5'd0) || last_in_region);

        if (last_in_region)
        begin
            bases_next = '0;
            phase_next = '0;
        end
        else
        begin
            bases_next = LEN_W'(b1);
            phase_next = LEN_W'(p1);
        end
    end

    // Keep the low 2*len bits of the rolling seed
    assign mask_shift     = 6'(TB) - {len5, 1'b0};
    assign seed_mask      = {TB{1'b1}} >> mask_shift;
    assign read_index_ext = 32'(read_index);

    // Table access request
    always_comb
    begin
        req_valid = accept && ((action == ACT_READ) || emit);
        if (action == ACT_READ)
        begin
            req_addr    = read_index_ext[TB-1:0];
            req.is_read = 1'b1;
            req.start   = '0;
            req.seq     = '0;
        end
        else
        begin
            req_addr    = rolling_next & seed_mask;
            req.is_read = 1'b0;
            req.start   = base_position - POS_W'(len5 - 5'd1);
            req.seq     = sequence_id;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_length_reg  <= SEED_LENGTH_RST;
            seed_overlap_reg <= SEED_OVERLAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED_LENGTH:  seed_length_reg  <= cfg_data;
                REG_SEED_OVERLAP: seed_overlap_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Region state, updated by base words only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rolling_reg <= '0;
            bases_reg   <= '0;
            phase_reg   <= '0;
        end
        else if (accept && (action == ACT_BASE))
        begin
            rolling_reg <= rolling_next;
            bases_reg   <= bases_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

[hdl/skc_counter.sv]
`timescale 1ns / 1ps

module skc_counter
    import skc_pkg::*;
#(
    parameter int MAX_SEED_LEN = MAX_SEED_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  skc_req_t                  req,
    input  logic [2*MAX_SEED_LEN-1:0] req_addr,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_is_read,
    output logic [VALUE_W-1:0]        out_value,
    output logic [POS_W-1:0]          out_start,
    output logic [SEQ_W-1:0]          out_seq,
    output logic [COUNT_W-1:0]        out_count
);

    localparam int TB = 2 * MAX_SEED_LEN;

    // Access stage: table data arrives here
    logic          s1_valid_reg;
    skc_req_t      s1_req_reg;
    logic [TB-1:0] s1_addr_reg;

    // Last write, forwarded over a read that raced it
    logic               byp_valid_reg;
    logic [TB-1:0]      byp_addr_reg;
    logic [COUNT_W-1:0] byp_data_reg;

    // Clearing sweep after reset
    logic          clearing_reg;
    logic [TB-1:0] clr_addr_reg;

    // Output register
    logic               out_valid_reg;
    logic               out_is_read_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [POS_W-1:0]   out_start_reg;
    logic [SEQ_W-1:0]   out_seq_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [COUNT_W-1:0] rdata;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] new_count;
    logic               s1_adv;
    logic               we;
    logic [TB-1:0]      waddr;
    logic [COUNT_W-1:0] wdata;
    logic [31:0]        addr_ext;

    skc_ram #(
        .WIDTH  (COUNT_W),
        .ADDR_W (TB)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (req_valid),
        .raddr (req_addr),
        .rdata (rdata)
    );

    // Handshake between stages
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing_reg && (!s1_valid_reg || s1_adv);

    // Forward and increment with saturation
    always_comb
    begin
        if (byp_valid_reg && (byp_addr_reg == s1_addr_reg))
        begin
            cur_count = byp_data_reg;
        end
        else
        begin
            cur_count = rdata;
        end
        new_count = (cur_count == COUNT_MAX) ? cur_count : (cur_count + COUNT_W'(1));
    end

    // Write port: clearing sweep, then count updates
    always_comb
    begin
        if (clearing_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = s1_adv && !s1_req_reg.is_read;
            waddr = s1_addr_reg;
            wdata = new_count;
        end
    end

    assign addr_ext = 32'(s1_addr_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (we)
            begin
                byp_valid_reg <= 1'b1;
            end

            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + TB'(1);
                if (clr_addr_reg == {TB{1'b1}})
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s1_req_reg  <= req;
            s1_addr_reg <= req_addr;
        end
        if (we)
        begin
            byp_addr_reg <= waddr;
            byp_data_reg <= wdata;
        end
        if (s1_adv)
        begin
            out_is_read_reg <= s1_req_reg.is_read;
            out_value_reg   <= addr_ext[VALUE_W-1:0];
            out_start_reg   <= s1_req_reg.start;
            out_seq_reg     <= s1_req_reg.seq;
            out_count_reg   <= s1_req_reg.is_read ? cur_count : new_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_is_read = out_is_read_reg;
    assign out_value   = out_value_reg;
    assign out_start   = out_start_reg;
    assign out_seq     = out_seq_reg;
    assign out_count   = out_count_reg;

endmodule

[hdl/strided_kmer_sampler_counter_unit.sv]
`timescale 1ns / 1ps

// Strided k-mer sampler and counter. Base words of one region stream in with a
// first mark (in tdata) and a last mark (tlast); tuser 0 feeds a base, tuser 1
// reads one entry of the count table. Sampled seeds bump their saturating count
// and come out with the new count; reads come back with the stored count. The
// block takes one word per clock as long as the output side keeps up, and each
// result passes the access-stage register and the output register; the rate is
// set by one read-modify-write of the single-port-write count memory per word,
// with the last write forwarded over the read that follows it. After reset the
// count memory is cleared one entry per clock, through all 4**MAX_SEED_LEN
// entries (4,194,304 at the default); s_axis_tready stays low until then, while
// configuration writes are taken at any time.
module strided_kmer_sampler_counter_unit
    import skc_pkg::*;
#(
    parameter int MAX_SEED_LEN = MAX_SEED_LEN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // base_code[1:0], first_in_region[2], base_position[34:3],
    // sequence_id[50:35], read_index[72:51], zero fill[79:73]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                   s_axis_tuser,
    // last_in_region
    input  logic                   s_axis_tlast,
    // Result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // seed_value[21:0], seed_start[53:22], seed_sequence[69:54],
    // seed_count[101:70], zero fill[103:102]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // is_read_reply[0]
    output logic                   m_axis_tuser
);

    localparam int TB = 2 * MAX_SEED_LEN;

    logic          accept;
    logic          req_valid;
    skc_req_t      req;
    logic [TB-1:0] req_addr;

    logic               out_is_read;
    logic [VALUE_W-1:0] out_value;
    logic [POS_W-1:0]   out_start;
    logic [SEQ_W-1:0]   out_seq;
    logic [COUNT_W-1:0] out_count;

    assign accept = s_axis_tvalid && s_axis_tready;

    skc_sampler #(
        .MAX_SEED_LEN (MAX_SEED_LEN)
    ) u_sampler (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .accept          (accept),
        .action          (s_axis_tuser),
        .base_code       (s_axis_tdata[1:0]),
        .first_in_region (s_axis_tdata[2]),
        .last_in_region  (s_axis_tlast),
        .base_position   (s_axis_tdata[34:3]),
        .sequence_id     (s_axis_tdata[50:35]),
        .read_index      (s_axis_tdata[72:51]),
        .req_valid       (req_valid),
        .req             (req),
        .req_addr        (req_addr)
    );

    skc_counter #(
        .MAX_SEED_LEN (MAX_SEED_LEN)
    ) u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req         (req),
        .req_addr    (req_addr),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_is_read (out_is_read),
        .out_value   (out_value),
        .out_start   (out_start),
        .out_seq     (out_seq),
        .out_count   (out_count)
    );

    assign m_axis_tdata = {2'b00, out_count, out_seq, out_start, out_value};
    assign m_axis_tuser = out_is_read;

endmodule

[hdl/skc_checker.sv]
`timescale 1ns / 1ps

module skc_checker
    import skc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // A stalled result word keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result word keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Read replies carry no start position and no sequence id
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[69:22] == '0)
        else $error("read reply with nonzero start or sequence");

    // A counted seed has been seen at least once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[101:70] != '0)
        else $error("emitted seed with zero count");

endmodule

bind strided_kmer_sampler_counter_unit skc_checker u_skc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
